// ===== hw/rtl/bsc_pkg.sv =====
// bsc_pkg: shared types and constants for the barometric compensation unit.
// No dependencies. Imported by every module of the block.
`timescale 1ns / 1ps
package bsc_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_TEMP       = 2'd0;
  localparam logic [1:0] CFG_PRESS_LOW  = 2'd1;
  localparam logic [1:0] CFG_PRESS_HIGH = 2'd2;
  localparam logic [1:0] CFG_PRESS_NINE = 2'd3;

  localparam logic [63:0] TF_OFFSET   = 64'd128000;
  localparam logic [63:0] DIV_SCALE   = 64'd3125;
  localparam logic [20:0] PP_BASE     = 21'd1048576;
  localparam logic [63:0] A_BIAS      = 64'h0000_8000_0000_0000;  // 1 << 47
  localparam logic [21:0] PA_MAX      = 22'h3F_FFFF;
  localparam logic [23:0] TC_MAX      = 24'h7F_FFFF;
  localparam logic [23:0] TC_MIN      = 24'h80_0000;

  typedef struct packed {
    logic [19:0] raw_t;
    logic [19:0] raw_p;
  } item_t;

  // Calibration set, all slices raw; T1 and P1 unsigned, the rest signed
  typedef struct packed {
    logic [15:0] t1;
    logic [15:0] t2;
    logic [15:0] t3;
    logic [15:0] p1;
    logic [15:0] p2;
    logic [15:0] p3;
    logic [15:0] p4;
    logic [15:0] p5;
    logic [15:0] p6;
    logic [15:0] p7;
    logic [15:0] p8;
    logic [15:0] p9;
  } coeff_t;

  typedef struct packed {
    logic [23:0] temp_centi;
    logic [21:0] press_pa;
    logic [31:0] fine_temp;
    logic        guard;
  } result_t;

  function automatic logic [63:0] sx64(input logic [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

endpackage

// ===== hw/rtl/bsc_front.sv =====
// bsc_front: accepts input words into a two-deep queue, holds calibration.
// Depends on bsc_pkg.
`timescale 1ns / 1ps
module bsc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bsc_pkg::item_t in_item_i,
  input  logic           cfg_valid_i,
  input  logic [1:0]     cfg_index_i,
  input  logic [63:0]    cfg_data_i,
  output bsc_pkg::coeff_t coeff_o,
  output logic           q_valid_o,
  output bsc_pkg::item_t q_item_o,
  input  logic           q_pop_i
);
  import bsc_pkg::*;

  item_t       mem_q [2];
  logic        wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push, pop;
  coeff_t      coeff_q;

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = mem_q[rd_ptr_q];
  assign coeff_o    = coeff_q;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

  // calibration registers, split into slices as written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coeff_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TEMP: begin
          coeff_q.t1 <= cfg_data_i[15:0];
          coeff_q.t2 <= cfg_data_i[31:16];
          coeff_q.t3 <= cfg_data_i[47:32];
        end
        CFG_PRESS_LOW: begin
          coeff_q.p1 <= cfg_data_i[15:0];
          coeff_q.p2 <= cfg_data_i[31:16];
          coeff_q.p3 <= cfg_data_i[47:32];
          coeff_q.p4 <= cfg_data_i[63:48];
        end
        CFG_PRESS_HIGH: begin
          coeff_q.p5 <= cfg_data_i[15:0];
          coeff_q.p6 <= cfg_data_i[31:16];
          coeff_q.p7 <= cfg_data_i[47:32];
          coeff_q.p8 <= cfg_data_i[63:48];
        end
        CFG_PRESS_NINE: begin
          coeff_q.p9 <= cfg_data_i[15:0];
        end
        default: begin
          coeff_q <= coeff_q;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/bsc_mul64.sv =====
// bsc_mul64: 64x64 wrapping product from one 32x32 multiplier.
// Depends on bsc_pkg (no symbols beyond the import convention).
`timescale 1ns / 1ps
module bsc_mul64 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [63:0] op_a_i,
  input  logic [63:0] op_b_i,
  output logic        done_o,
  output logic [63:0] prod_o
);
  import bsc_pkg::*;

  logic [1:0]  cnt_q, cnt_d;
  logic [63:0] acc_q, acc_d;
  logic [31:0] x, y;
  logic [63:0] pp;

  // low*low, low*high, high*low; the high*high term falls off the top
  always_comb begin
    case (cnt_q)
      2'd0:    begin x = op_a_i[31:0];  y = op_b_i[31:0];  end
      2'd1:    begin x = op_a_i[31:0];  y = op_b_i[63:32]; end
      default: begin x = op_a_i[63:32]; y = op_b_i[31:0];  end
    endcase
    pp = 64'(x) * 64'(y);
    if (cnt_q == 2'd0) begin
      acc_d = pp;
    end else if (cnt_q == 2'd3) begin
      acc_d = acc_q;
    end else begin
      acc_d = acc_q + {pp[31:0], 32'd0};
    end
    cnt_d = go_i ? cnt_q + 2'd1 : 2'd0;
  end

  assign done_o = go_i && (cnt_q == 2'd3);
  assign prod_o = acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

endmodule

// ===== hw/rtl/bsc_div64.sv =====
// bsc_div64: signed 64-bit division, truncating, one quotient bit a cycle.
// Depends on bsc_pkg (import convention only).
`timescale 1ns / 1ps
module bsc_div64 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        go_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);
  import bsc_pkg::*;

  logic        busy_q, fin_q;
  logic [5:0]  cnt_q;
  logic [63:0] rem_q, quo_q, den_q;
  logic        neg_q;
  logic [64:0] trial;
  logic [64:0] diff;
  logic        ge;
  logic        load;

  assign load   = go_i && !busy_q && !fin_q;
  assign trial  = {rem_q, quo_q[63]};
  assign diff   = trial - {1'b0, den_q};
  assign ge     = !diff[64];
  assign done_o = go_i && fin_q;
  assign quo_o  = neg_q ? (64'd0 - quo_q) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (done_o) begin
        fin_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q <= 64'd0;
      quo_q <= num_i[63] ? 64'd0 - num_i : num_i;
      den_q <= den_i[63] ? 64'd0 - den_i : den_i;
      neg_q <= num_i[63] ^ den_i[63];
    end else if (busy_q) begin
      rem_q <= ge ? diff[63:0] : trial[63:0];
      quo_q <= {quo_q[62:0], ge};
    end
  end

endmodule

// ===== hw/rtl/bsc_back.sv =====
// bsc_back: sequencer that runs the compensation on the shared multiplier
// and divider, with the output register. Depends on bsc_pkg, bsc_mul64, bsc_div64.
`timescale 1ns / 1ps
module bsc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bsc_pkg::coeff_t  coeff_i,
  input  logic             q_valid_i,
  input  bsc_pkg::item_t   q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output bsc_pkg::result_t out_o
);
  import bsc_pkg::*;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_V1   = 5'd1;
  localparam logic [4:0] ST_D2   = 5'd2;
  localparam logic [4:0] ST_V2   = 5'd3;
  localparam logic [4:0] ST_A0   = 5'd4;
  localparam logic [4:0] ST_AA   = 5'd5;
  localparam logic [4:0] ST_B6   = 5'd6;
  localparam logic [4:0] ST_B5   = 5'd7;
  localparam logic [4:0] ST_A3   = 5'd8;
  localparam logic [4:0] ST_A2   = 5'd9;
  localparam logic [4:0] ST_A1   = 5'd10;
  localparam logic [4:0] ST_CHK  = 5'd11;
  localparam logic [4:0] ST_N    = 5'd12;
  localparam logic [4:0] ST_DIV  = 5'd13;
  localparam logic [4:0] ST_Q9   = 5'd14;
  localparam logic [4:0] ST_QQ   = 5'd15;
  localparam logic [4:0] ST_Q8   = 5'd16;
  localparam logic [4:0] ST_R    = 5'd17;
  localparam logic [4:0] ST_OUT  = 5'd18;

  logic [4:0]  state_q, state_d;
  logic [19:0] raw_p_q, raw_p_d;
  logic [31:0] d1_q, d1_d, d2_q, d2_d, v1_q, v1_d, x_q, x_d, tf_q, tf_d;
  logic [23:0] tc_q, tc_d;
  logic [63:0] a0_q, a0_d, aa_q, aa_d, b_q, b_d, a_q, a_d;
  logic [63:0] num_q, num_d, qt_q, qt_d, w_q, w_d;
  logic [21:0] pa_q, pa_d;
  logic        guard_q, guard_d;
  logic        out_valid_q, out_valid_d;
  result_t     out_q, out_d;

  logic        mul_go, mul_done, div_go, div_done;
  logic [63:0] op_a, op_b, mres, dres, qs;
  logic [34:0] tf_ext, tv;
  logic [26:0] tcw;
  logic [20:0] pp;
  logic [63:0] r;

  bsc_mul64 u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mul_go),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .done_o (mul_done),
    .prod_o (mres)
  );

  bsc_div64 u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (div_go),
    .num_i  (num_q),
    .den_i  (a_q),
    .done_o (div_done),
    .quo_o  (dres)
  );

  assign qs     = 64'($signed(qt_q) >>> 13);
  assign div_go = (state_q == ST_DIV);

  // operand selection for the shared multiplier
  always_comb begin
    mul_go = 1'b1;
    op_a   = 64'd0;
    op_b   = 64'd0;
    unique case (state_q)
      ST_V1:   begin op_a = {32'd0, d1_q}; op_b = sx64(coeff_i.t2); end
      ST_D2:   begin op_a = {32'd0, d2_q}; op_b = {32'd0, d2_q}; end
      ST_V2:   begin op_a = {32'd0, x_q};  op_b = sx64(coeff_i.t3); end
      ST_AA:   begin op_a = a0_q;          op_b = a0_q; end
      ST_B6:   begin op_a = aa_q;          op_b = sx64(coeff_i.p6); end
      ST_B5:   begin op_a = a0_q;          op_b = sx64(coeff_i.p5); end
      ST_A3:   begin op_a = aa_q;          op_b = sx64(coeff_i.p3); end
      ST_A2:   begin op_a = a0_q;          op_b = sx64(coeff_i.p2); end
      ST_A1:   begin op_a = a_q;           op_b = {48'd0, coeff_i.p1}; end
      ST_N:    begin op_a = num_q;         op_b = DIV_SCALE; end
      ST_Q9:   begin op_a = sx64(coeff_i.p9); op_b = qs; end
      ST_QQ:   begin op_a = w_q;           op_b = qs; end
      ST_Q8:   begin op_a = sx64(coeff_i.p8); op_b = qt_q; end
      default: begin mul_go = 1'b0; end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    raw_p_d     = raw_p_q;
    d1_d        = d1_q;
    d2_d        = d2_q;
    v1_d        = v1_q;
    x_d         = x_q;
    tf_d        = tf_q;
    tc_d        = tc_q;
    a0_d        = a0_q;
    aa_d        = aa_q;
    b_d         = b_q;
    a_d         = a_q;
    num_d       = num_q;
    qt_d        = qt_q;
    w_d         = w_q;
    pa_d        = pa_q;
    guard_d     = guard_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    q_pop_o     = 1'b0;

    tf_ext = {{3{tf_q[31]}}, tf_q};
    tv     = (tf_ext << 2) + tf_ext + 35'd128;
    tcw    = tv[34:8];
    pp     = PP_BASE - {1'b0, raw_p_q};
    r      = 64'($signed(w_q) >>> 8) + (sx64(coeff_i.p7) << 4);

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          raw_p_d = q_item_i.raw_p;
          d1_d    = {15'd0, q_item_i.raw_t[19:3]} - {15'd0, coeff_i.t1, 1'b0};
          d2_d    = {16'd0, q_item_i.raw_t[19:4]} - {16'd0, coeff_i.t1};
          state_d = ST_V1;
        end
      end
      ST_V1: if (mul_done) begin
        v1_d    = 32'($signed(mres[31:0]) >>> 11);
        state_d = ST_D2;
      end
      ST_D2: if (mul_done) begin
        x_d     = 32'($signed(mres[31:0]) >>> 12);
        state_d = ST_V2;
      end
      ST_V2: if (mul_done) begin
        tf_d    = v1_q + 32'($signed(mres[31:0]) >>> 14);
        state_d = ST_A0;
      end
      ST_A0: begin
        a0_d = {{32{tf_q[31]}}, tf_q} - TF_OFFSET;
        // centi-degrees: floor((5*tf + 128) / 256), saturated to 24 bits
        if (tcw[26:23] == {4{tcw[26]}}) begin
          tc_d = tcw[23:0];
        end else begin
          tc_d = tcw[26] ? TC_MIN : TC_MAX;
        end
        state_d = ST_AA;
      end
      ST_AA: if (mul_done) begin
        aa_d    = mres;
        state_d = ST_B6;
      end
      ST_B6: if (mul_done) begin
        b_d     = mres;
        state_d = ST_B5;
      end
      ST_B5: if (mul_done) begin
        b_d     = b_q + (mres << 17) + (sx64(coeff_i.p4) << 35);
        state_d = ST_A3;
      end
      ST_A3: if (mul_done) begin
        w_d     = 64'($signed(mres) >>> 8);
        state_d = ST_A2;
      end
      ST_A2: if (mul_done) begin
        a_d     = w_q + (mres << 12) + A_BIAS;
        state_d = ST_A1;
      end
      ST_A1: if (mul_done) begin
        a_d     = 64'($signed(mres) >>> 33);
        state_d = ST_CHK;
      end
      ST_CHK: begin
        num_d = ({43'd0, pp} << 31) - b_q;
        if (a_q == 64'd0) begin
          guard_d = 1'b1;
          pa_d    = 22'd0;
          state_d = ST_OUT;
        end else begin
          guard_d = 1'b0;
          state_d = ST_N;
        end
      end
      ST_N: if (mul_done) begin
        num_d   = mres;
        state_d = ST_DIV;
      end
      ST_DIV: if (div_done) begin
        qt_d    = dres;
        state_d = ST_Q9;
      end
      ST_Q9: if (mul_done) begin
        w_d     = mres;
        state_d = ST_QQ;
      end
      ST_QQ: if (mul_done) begin
        w_d     = 64'($signed(mres) >>> 25);
        state_d = ST_Q8;
      end
      ST_Q8: if (mul_done) begin
        w_d     = qt_q + w_q + 64'($signed(mres) >>> 19);
        state_d = ST_R;
      end
      ST_R: begin
        if (r[63]) begin
          pa_d = 22'd0;
        end else if (r[62:30] != 33'd0) begin
          pa_d = PA_MAX;
        end else begin
          pa_d = r[29:8];
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d      = 1'b1;
          out_d.temp_centi = tc_q;
          out_d.press_pa   = pa_q;
          out_d.fine_temp  = tf_q;
          out_d.guard      = guard_q;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raw_p_q <= raw_p_d;
    d1_q    <= d1_d;
    d2_q    <= d2_d;
    v1_q    <= v1_d;
    x_q     <= x_d;
    tf_q    <= tf_d;
    tc_q    <= tc_d;
    a0_q    <= a0_d;
    aa_q    <= aa_d;
    b_q     <= b_d;
    a_q     <= a_d;
    num_q   <= num_d;
    qt_q    <= qt_d;
    w_q     <= w_d;
    pa_q    <= pa_d;
    guard_q <= guard_d;
    out_q   <= out_d;
  end

  a_guard_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.guard |-> out_q.press_pa == 22'd0)
    else $error("guarded word carries non-zero pressure");

  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_go && div_go))
    else $error("multiplier and divider both selected");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> state_q == ST_V1)
    else $error("queue popped outside idle");

endmodule

// ===== hw/rtl/baro_sensor_compensation_unit.sv =====
// baro_sensor_compensation_unit: top level of the barometric compensation block.
// Depends on bsc_pkg, bsc_front, bsc_back (and through it bsc_mul64, bsc_div64).
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------
//  in      | input     | in_valid_i/in_ready_o  | raw_temperature_i, raw_pressure_i
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_index_i, cfg_data_i
//  out     | output    | out_valid_o/out_ready_i| temperature_centi_o, pressure_pa_o,
//          |           |                        | fine_temperature_o, divide_guard_o
//
// In the back end each word takes thirteen 64-bit products on the shared
// 32x32 multiplier and one division on the radix-2 divider. A zero divisor
// skips the division and the final correction. Reset clears the queue,
// the sequencer, the output valid and all calibration registers to zero.
// cfg_ready_o is always high. The front queue holds two words, so input is
// taken while the back end is busy or its result waits on out_ready_i.
`timescale 1ns / 1ps
module baro_sensor_compensation_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [19:0] raw_temperature_i,
  input  logic [19:0] raw_pressure_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [23:0] temperature_centi_o,
  output logic [21:0] pressure_pa_o,
  output logic signed [31:0] fine_temperature_o,
  output logic        divide_guard_o
);
  import bsc_pkg::*;

  item_t   in_item, q_item;
  coeff_t  coeff;
  result_t res;
  logic    q_valid, q_pop;

  assign in_item.raw_t = raw_temperature_i;
  assign in_item.raw_p = raw_pressure_i;
  assign cfg_ready_o   = 1'b1;

  // front: input queue and calibration registers
  bsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .coeff_o     (coeff),
    .q_valid_o   (q_valid),
    .q_item_o    (q_item),
    .q_pop_i     (q_pop)
  );

  // back: sequenced arithmetic and output register
  bsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .coeff_i     (coeff),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res)
  );

  assign temperature_centi_o = res.temp_centi;
  assign pressure_pa_o       = res.press_pa;
  assign fine_temperature_o  = res.fine_temp;
  assign divide_guard_o      = res.guard;

endmodule

// ===== test/baro_sensor_compensation_unit_tb.sv =====
// Self-checking bench for baro_sensor_compensation_unit: directed table, then random words.
// Depends on bsc_pkg and the RTL top; predicts each result in-bench and compares.
`timescale 1ns / 1ps
module baro_sensor_compensation_unit_tb;
  import bsc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [19:0] raw_temperature_i = '0;
  logic [19:0] raw_pressure_i = '0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_TEMP;
  logic [63:0] cfg_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic signed [23:0] temperature_centi_o;
  logic [21:0] pressure_pa_o;
  logic signed [31:0] fine_temperature_o;
  logic        divide_guard_o;

  baro_sensor_compensation_unit u_top (.*);

  always #5 clk_i = ~clk_i;

  // Bench copy of the calibration registers
  logic [47:0] temp_cal;
  logic [63:0] press_cal_low, press_cal_high;
  logic [15:0] press_cal_nine;

  result_t reading_q[$];      // predicted readings, oldest first
  int      err_cnt = 0;
  int      tx_idle = 0, rx_idle = 0;
  int      hold_cycles = 0;    // receiver hold-off, counted down by the receiver

  // Directed rows: phase selects a calibration set; typed rows carry their answer
  typedef struct {
    int          phase;
    logic [19:0] rt, rp;
    bit          typed;
    result_t     want;
  } row_t;
  row_t rows[$];

  // Compensation predictor: fine temp at 32 bits, pressure at 64 bits, wrapping
  function automatic result_t compute_reading(logic [19:0] rt, logic [19:0] rp);
    logic [31:0] t1w, t2w, t3w, d1, d2, v1, v2, sq, tf;
    logic signed [63:0] tfs, tc, a, b, a2, a3, pp, num, q, qs, c1, c2, r, pa;
    logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [63:0] mn, md, uq;
    result_t res;
    t1w = {16'b0, temp_cal[15:0]};
    t2w = {{16{temp_cal[31]}}, temp_cal[31:16]};
    t3w = {{16{temp_cal[47]}}, temp_cal[47:32]};
    d1  = {15'b0, rt[19:3]} - {t1w[30:0], 1'b0};
    v1  = $signed(d1 * t2w) >>> 11;
    d2  = {16'b0, rt[19:4]} - t1w;
    sq  = $signed(d2 * d2) >>> 12;
    v2  = $signed(sq * t3w) >>> 14;
    tf  = v1 + v2;
    tfs = 64'($signed(tf));
    // floor shift, then clamp to 24-bit signed
    tc = (tfs * 64'sd5 + 64'sd128) >>> 8;
    if (tc > 64'sd8388607) tc = 64'sd8388607;
    if (tc < -64'sd8388608) tc = -64'sd8388608;
    p1 = {48'b0, press_cal_low[15:0]};
    p2 = {{48{press_cal_low[31]}}, press_cal_low[31:16]};
    p3 = {{48{press_cal_low[47]}}, press_cal_low[47:32]};
    p4 = {{48{press_cal_low[63]}}, press_cal_low[63:48]};
    p5 = {{48{press_cal_high[15]}}, press_cal_high[15:0]};
    p6 = {{48{press_cal_high[31]}}, press_cal_high[31:16]};
    p7 = {{48{press_cal_high[47]}}, press_cal_high[47:32]};
    p8 = {{48{press_cal_high[63]}}, press_cal_high[63:48]};
    p9 = {{48{press_cal_nine[15]}}, press_cal_nine};
    a  = tfs - 64'sd128000;
    b  = a * a * p6 + ((a * p5) <<< 17) + (p4 <<< 35);
    a2 = ((a * a * p3) >>> 8) + ((a * p2) <<< 12);
    a3 = ((64'sh0000_8000_0000_0000 + a2) * p1) >>> 33;
    res.temp_centi = tc[23:0];
    res.fine_temp  = tf;
    res.press_pa   = '0;
    res.guard      = (a3 == 0);
    if (a3 != 0) begin
      pp  = 64'sd1048576 - $signed({44'b0, rp});
      num = ((pp <<< 31) - b) * 64'sd3125;
      // truncating divide on magnitudes; min / -1 wraps to itself
      mn = num[63] ? -num : num;
      md = a3[63] ? -a3 : a3;
      uq = mn / md;
      q  = (num[63] ^ a3[63]) ? -uq : uq;
      qs = q >>> 13;
      c1 = (p9 * qs * qs) >>> 25;
      c2 = (p8 * q) >>> 19;
      r  = ((q + c1 + c2) >>> 8) + (p7 <<< 4);
      if (!r[63]) begin
        pa = r >>> 8;
        if (pa > 64'sd4194303) pa = 64'sd4194303;
        res.press_pa = pa[21:0];
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // Result checker: compare each accepted word with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (reading_q.size() == 0) begin
        report_mismatch("unexpected word", 64'({fine_temperature_o, pressure_pa_o}), '0);
      end else begin
        result_t w;
        w = reading_q.pop_front();
        if (temperature_centi_o !== w.temp_centi)
          report_mismatch("temperature_centi", 64'(temperature_centi_o), 64'(w.temp_centi));
        if (pressure_pa_o !== w.press_pa)
          report_mismatch("pressure_pa", 64'(pressure_pa_o), 64'(w.press_pa));
        if (fine_temperature_o !== w.fine_temp)
          report_mismatch("fine_temperature", 64'(fine_temperature_o), 64'(w.fine_temp));
        if (divide_guard_o !== w.guard)
          report_mismatch("divide_guard", 64'(divide_guard_o), 64'(w.guard));
      end
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // One register write; caller lowers cfg_valid_i after the last one
  task automatic write_reg(logic [1:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_TEMP:       temp_cal       = data[47:0];
      CFG_PRESS_LOW:  press_cal_low  = data;
      CFG_PRESS_HIGH: press_cal_high = data;
      CFG_PRESS_NINE: press_cal_nine = data[15:0];
      default: ;
    endcase
  endtask

  // Wait until every predicted word has come back, with valid low
  task automatic drain();
    in_valid_i <= 1'b0;
    wait (reading_q.size() == 0);
    @(posedge clk_i);
  endtask

  task automatic load_cal(logic [63:0] t, logic [63:0] lo, logic [63:0] hi, logic [63:0] n9);
    drain();
    write_reg(CFG_TEMP, t);
    write_reg(CFG_PRESS_LOW, lo);
    write_reg(CFG_PRESS_HIGH, hi);
    write_reg(CFG_PRESS_NINE, n9);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Offer one word; the prediction is queued on acceptance
  task automatic send_reading(logic [19:0] rt, logic [19:0] rp, bit typed, result_t want);
    if (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    raw_temperature_i <= rt;
    raw_pressure_i    <= rp;
    do @(posedge clk_i); while (!in_ready_o);
    reading_q.push_back(typed ? want : compute_reading(rt, rp));
  endtask

  function automatic row_t mk_row(int ph, logic [19:0] rt, logic [19:0] rp, bit typed);
    row_t r;
    r.phase = ph; r.rt = rt; r.rp = rp; r.typed = typed;
    // zero calibration: fine temp 0, temperature 0, divisor 0 so guard set
    r.want = '{temp_centi: '0, press_pa: '0, fine_temp: '0, guard: 1'b1};
    return r;
  endfunction

  // Typical factory calibration set
  localparam logic [63:0] TYP_T  = 64'h0000_FC18_6743_6B70;
  localparam logic [63:0] TYP_LO = 64'h0B27_0BD0_D643_8E7D;
  localparam logic [63:0] TYP_HI = 64'hC6F8_3C8C_FFF9_008C;
  localparam logic [63:0] TYP_N9 = 64'h0000_0000_0000_1770;

  initial begin
    int cur_phase;
    logic [19:0] rt;
    result_t none;
    none = '0;
    temp_cal = '0; press_cal_low = '0; press_cal_high = '0; press_cal_nine = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase 0 runs on reset calibration: answers typed in
    rows.push_back(mk_row(0, 20'h00000, 20'h00000, 1));
    rows.push_back(mk_row(0, 20'hFFFFF, 20'hFFFFF, 1));
    rows.push_back(mk_row(0, 20'h00000, 20'hFFFFF, 1));
    rows.push_back(mk_row(0, 20'hFFFFF, 20'h00000, 1));
    rows.push_back(mk_row(0, 20'h80000, 20'h55555, 1));
    rows.push_back(mk_row(1, 20'h00000, 20'h00000, 0));
    rows.push_back(mk_row(1, 20'hFFFFF, 20'hFFFFF, 0));
    rows.push_back(mk_row(1, 20'h7EED0, 20'h655AC, 0));
    rows.push_back(mk_row(1, 20'h00000, 20'hFFFFF, 0));
    rows.push_back(mk_row(1, 20'hFFFFF, 20'h00000, 0));
    rows.push_back(mk_row(1, 20'h80000, 20'h80000, 0));
    rows.push_back(mk_row(2, 20'h00000, 20'h00000, 0));
    rows.push_back(mk_row(2, 20'hFFFFF, 20'hFFFFF, 0));
    rows.push_back(mk_row(2, 20'h7FFFF, 20'h00001, 0));
    rows.push_back(mk_row(2, 20'hAAAAA, 20'h55555, 0));
    rows.push_back(mk_row(3, 20'h00000, 20'h00000, 0));
    rows.push_back(mk_row(3, 20'hFFFFF, 20'hFFFFF, 0));
    rows.push_back(mk_row(3, 20'h55555, 20'hAAAAA, 0));
    rows.push_back(mk_row(3, 20'h00010, 20'hFFFF0, 0));

    cur_phase = 0;
    foreach (rows[i]) begin
      if (rows[i].phase != cur_phase) begin
        cur_phase = rows[i].phase;
        case (cur_phase)
          1: load_cal(TYP_T, TYP_LO, TYP_HI, TYP_N9);
          // all ones, junk above the kept bits of the narrow registers
          2: load_cal('1, '1, '1, '1);
          // most negative signed slices, T1 and P1 at max
          default: load_cal(64'hABCD_8000_8000_FFFF, 64'h8000_8000_8000_FFFF,
                            64'h8000_8000_8000_8000, 64'h1234_5678_9ABC_8000);
        endcase
      end
      send_reading(rows[i].rt, rows[i].rp, rows[i].typed, rows[i].want);
    end

    // Random part: three idling regimes
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle = (ph == 0) ? 27 : (ph == 1) ? 76 : 0;
      rx_idle = (ph == 0) ? 76 : (ph == 1) ? 27 : 0;
      for (int n = 0; n < 650; n++) begin
        if (n % 130 == 0) begin
          case ($urandom_range(9))
            0, 1: load_cal({$urandom, $urandom}, {$urandom, $urandom},
                           {$urandom, $urandom}, {$urandom, $urandom});
            // divisor forced to zero with P1 cleared
            2: load_cal({$urandom, $urandom}, {$urandom, $urandom} & ~64'hFFFF,
                        {$urandom, $urandom}, {$urandom, $urandom});
            default: load_cal(TYP_T ^ {16'h0, {3{12'h0, 4'($urandom)}}},
                              TYP_LO ^ {4{12'h0, 4'($urandom)}},
                              TYP_HI ^ {4{12'h0, 4'($urandom)}},
                              TYP_N9 ^ {48'h0, 8'h0, 8'($urandom)});
          endcase
        end
        if (ph == 0 && n == 300) hold_cycles = 600;  // long receiver hold-off
        if (ph == 1 && n == 300) drain();             // sender waits for all words
        rt = ($urandom_range(3) == 0) ? 20'($urandom) : 20'($urandom_range(20'h60000, 20'h90000));
        send_reading(rt, 20'($urandom), 1'b0, none);
      end
    end
    in_valid_i <= 1'b0;

    wait (reading_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // Run limit
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
